### hdl/jrpw_pkg.sv
// Shared types, constants and the elaboration-time coefficient table builder
// for the parallel-beam ray pixel weight pipeline. Depends on nothing.
`timescale 1ns / 1ps

package jrpw_pkg;

	// Field widths of the item and result ports
	localparam int ANGLE_W = 8;
	localparam int DETECTOR_W = 10;
	localparam int STEP_W = 9;
	localparam int INDEX_W = 18;
	localparam int WEIGHT_W = 17;

	// Configuration register widths and reset values
	localparam int IMAGE_SIZE_W = 10;
	localparam int DET_COUNT_W = 11;
	localparam int SPACING_W = 24;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [IMAGE_SIZE_W-1:0] IMAGE_SIZE_RESET = 10'd256;
	localparam logic [DET_COUNT_W-1:0] DET_COUNT_RESET = 11'd256;
	localparam logic [SPACING_W-1:0] SPACING_RESET = 24'd65536;

	// Parameter defaults
	localparam int ANGLE_COUNT_DEF = 256;
	localparam int MAX_IMAGE_SIZE_DEF = 512;
	localparam int MAX_DETECTORS_DEF = 1024;
	localparam int FRACTION_BITS_DEF = 16;

	// Internal datapath widths
	localparam int ANGLE_DEPTH = 1 << ANGLE_W;
	localparam int COEF_W = 31;
	localparam int RAY_W = 54;
	localparam int FRAC_W = 32;
	localparam int FL_W = RAY_W - FRAC_W;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_SIZE = 2'd0,
		REG_DETECTOR_COUNT = 2'd1,
		REG_DETECTOR_SPACING = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle_index;
		logic [DETECTOR_W-1:0] detector_index;
		logic [STEP_W-1:0] step_index;
	} request_t;

	typedef struct packed {
		logic [INDEX_W-1:0] row_index;
		logic [INDEX_W-1:0] first_column;
		logic [WEIGHT_W-1:0] first_weight;
		logic first_valid;
		logic [INDEX_W-1:0] second_column;
		logic [WEIGHT_W-1:0] second_weight;
		logic second_valid;
	} result_t;

	// Clamped configuration as the datapath sees it
	typedef struct packed {
		logic [IMAGE_SIZE_W-1:0] nx;
		logic [DET_COUNT_W-1:0] nr;
		logic [SPACING_W-1:0] spacing;
	} cfg_t;

	// Per-angle coefficients: tan/cot and 1/|cos| or 1/|sin| in Q30
	typedef struct packed {
		logic angle_ok;
		logic flip;
		logic xdrv;
		logic [COEF_W-1:0] k;
		logic [COEF_W-1:0] m;
	} coef_t;

	typedef coef_t [ANGLE_DEPTH-1:0] coef_table_t;

	// Ray position handed from the geometry pipe to the weight stage
	typedef struct packed {
		logic valid;
		logic [INDEX_W-1:0] row;
		logic [STEP_W-1:0] step;
		logic [COEF_W-1:0] m;
		logic xdrv;
		logic angle_ok;
		logic [FL_W-1:0] fl;
		logic [FRAC_W-1:0] frac;
	} ray_t;

	// Restoring division, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] umod64(input logic [63:0] num, input logic [63:0] den);
		return num - udiv64(num, den) * den;
	endfunction

	// floor(a*b / 2^s), low 64 bits
	function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
			input int unsigned s);
		logic [127:0] prod;
		prod = {64'd0, a} * {64'd0, b};
		prod = prod >> s;
		return prod[63:0];
	endfunction

	// Taylor sin and cos of pi*num/den in Q60, returned as {sin, cos}
	function automatic logic [127:0] sin_cos_q60(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] phi, p2, ts, tc, s, c;
		phi = udiv64(PI_Q60, den) * num + udiv64(umod64(PI_Q60, den) * num, den);
		p2 = mul_shr(phi, phi, 60);
		ts = phi;
		tc = ONE_Q60;
		s = '0;
		c = '0;
		for (int k = 1; k <= 12; k++) begin
			if ((k & 1) != 0) begin
				s = s + ts;
				c = c + tc;
			end else begin
				s = s - ts;
				c = c - tc;
			end
			ts = udiv64(mul_shr(ts, p2, 60), 64'((2 * k) * (2 * k + 1)));
			tc = udiv64(mul_shr(tc, p2, 60), 64'((2 * k - 1) * (2 * k)));
		end
		return {s, c};
	endfunction

	// Build the per-angle coefficient table for a given angle count
	function automatic coef_table_t build_coef_table(input int unsigned angle_count);
		coef_table_t tbl;
		logic [63:0] d, a, np, s30, c30;
		logic [127:0] sc;
		logic flip, xdrv;
		tbl = '0;
		d = 64'(angle_count);
		for (int i = 0; i < ANGLE_DEPTH; i++) begin
			a = 64'(i);
			if (a < d) begin
				flip = (2 * a) > d;
				np = flip ? d - a : a;
				xdrv = (4 * np) < d;
				sc = xdrv ? sin_cos_q60(np, d) : sin_cos_q60(d - 2 * np, 2 * d);
				s30 = (sc[127:64] + (64'd1 << 29)) >> 30;
				c30 = (sc[63:0] + (64'd1 << 29)) >> 30;
				if (c30 == 64'd0)
					c30 = 64'd1;
				tbl[ANGLE_W'(i)].angle_ok = 1'b1;
				tbl[ANGLE_W'(i)].flip = flip;
				tbl[ANGLE_W'(i)].xdrv = xdrv;
				tbl[ANGLE_W'(i)].k = COEF_W'(udiv64((s30 << 30) + (c30 >> 1), c30));
				tbl[ANGLE_W'(i)].m = COEF_W'(udiv64(ONE_Q60 + (c30 >> 1), c30));
			end
		end
		return tbl;
	endfunction

endpackage

### hdl/jrpw_cfg_regs.sv
// Configuration register file with clamping of image size and detector count.
// Depends on jrpw_pkg.
`timescale 1ns / 1ps

module jrpw_cfg_regs #(
	parameter int MAX_IMAGE_SIZE = jrpw_pkg::MAX_IMAGE_SIZE_DEF,
	parameter int MAX_DETECTORS = jrpw_pkg::MAX_DETECTORS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [jrpw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [jrpw_pkg::CFG_DATA_W-1:0] cfg_data,
	output jrpw_pkg::cfg_t cfg
);

	localparam int NX_FULL = (1 << jrpw_pkg::IMAGE_SIZE_W) - 1;
	localparam int NR_FULL = (1 << jrpw_pkg::DET_COUNT_W) - 1;
	localparam logic [jrpw_pkg::IMAGE_SIZE_W-1:0] NX_CAP =
		jrpw_pkg::IMAGE_SIZE_W'((MAX_IMAGE_SIZE > NX_FULL) ? NX_FULL : MAX_IMAGE_SIZE);
	localparam logic [jrpw_pkg::DET_COUNT_W-1:0] NR_CAP =
		jrpw_pkg::DET_COUNT_W'((MAX_DETECTORS > NR_FULL) ? NR_FULL : MAX_DETECTORS);

	logic [jrpw_pkg::IMAGE_SIZE_W-1:0] image_size_q;
	logic [jrpw_pkg::DET_COUNT_W-1:0] detector_count_q;
	logic [jrpw_pkg::SPACING_W-1:0] detector_spacing_q;

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= jrpw_pkg::IMAGE_SIZE_RESET;
			detector_count_q <= jrpw_pkg::DET_COUNT_RESET;
			detector_spacing_q <= jrpw_pkg::SPACING_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				jrpw_pkg::REG_IMAGE_SIZE: begin
					image_size_q <= cfg_data[jrpw_pkg::IMAGE_SIZE_W-1:0];
				end
				jrpw_pkg::REG_DETECTOR_COUNT: begin
					detector_count_q <= cfg_data[jrpw_pkg::DET_COUNT_W-1:0];
				end
				jrpw_pkg::REG_DETECTOR_SPACING: begin
					detector_spacing_q <= cfg_data[jrpw_pkg::SPACING_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Clamp to the supported maxima
	always_comb begin
		cfg.nx = (image_size_q > NX_CAP) ? NX_CAP : image_size_q;
		cfg.nr = (detector_count_q > NR_CAP) ? NR_CAP : detector_count_q;
		cfg.spacing = detector_spacing_q;
	end

endmodule

### hdl/jrpw_ray_pipe.sv
// Geometry pipe, stages 1 to 4: coefficient lookup, detector offset and the
// crossing coordinate of the ray in Q32. Depends on jrpw_pkg.
`timescale 1ns / 1ps

module jrpw_ray_pipe #(
	parameter int ANGLE_COUNT = jrpw_pkg::ANGLE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input jrpw_pkg::request_t request,
	input jrpw_pkg::cfg_t cfg,
	output jrpw_pkg::ray_t ray
);

	localparam jrpw_pkg::coef_table_t COEF_TABLE = jrpw_pkg::build_coef_table(ANGLE_COUNT);
	localparam int CW = jrpw_pkg::COEF_W;
	localparam int RW = jrpw_pkg::RAY_W;
	localparam int A_W = jrpw_pkg::DET_COUNT_W + jrpw_pkg::SPACING_W;
	localparam int A_SPLIT = 17;
	localparam int RM_SHIFT = 15;
	localparam int PH_W = A_W - A_SPLIT + CW;
	localparam int PL_W = A_SPLIT + CW;
	localparam int RM_FULL_W = PH_W + A_SPLIT;
	localparam int Q2_W = jrpw_pkg::IMAGE_SIZE_W + 2;
	localparam int R2_W = jrpw_pkg::DET_COUNT_W + 2;
	localparam int KQ_W = CW + 1 + Q2_W;
	localparam int BASE_W = jrpw_pkg::IMAGE_SIZE_W + 1 + 31;

	// Stage 1 logic
	jrpw_pkg::coef_t coef;
	logic [jrpw_pkg::INDEX_W:0] row_full;
	logic signed [Q2_W-1:0] q2;
	logic signed [R2_W-1:0] r2;

	always_comb begin
		coef = COEF_TABLE[request.angle_index];
		row_full = (jrpw_pkg::INDEX_W+1)'(request.angle_index) * (jrpw_pkg::INDEX_W+1)'(cfg.nr)
			+ (jrpw_pkg::INDEX_W+1)'(request.detector_index);
		q2 = $signed({2'b00, request.step_index, 1'b0}) - $signed({2'b00, cfg.nx})
			+ Q2_W'(1);
		r2 = $signed({2'b00, request.detector_index, 1'b0}) - $signed({2'b00, cfg.nr})
			+ R2_W'(1);
	end

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic [jrpw_pkg::INDEX_W-1:0] row_s1, row_s2, row_s3, row_s4;
	logic [jrpw_pkg::STEP_W-1:0] step_s1, step_s2, step_s3, step_s4;
	jrpw_pkg::coef_t coef_s1;
	logic signed [Q2_W-1:0] q2_s1;
	logic [jrpw_pkg::DET_COUNT_W-1:0] rmag_s1;
	logic rneg_s1, rneg_s2, rneg_s3;
	logic [CW-1:0] m_s2, m_s3, m_s4;
	logic xdrv_s2, xdrv_s3, xdrv_s4;
	logic ok_s2, ok_s3, ok_s4;
	logic [A_W-1:0] a_s2;
	logic signed [KQ_W-1:0] kq_s2;
	logic [PH_W-1:0] ph_s3;
	logic [PL_W-1:0] pl_s3;
	logic signed [RW-1:0] bk_s3;
	logic signed [RW-1:0] ray_s4;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1: table read, centered step and detector offsets, row index
	always_ff @(posedge clk) begin
		row_s1 <= row_full[jrpw_pkg::INDEX_W-1:0];
		step_s1 <= request.step_index;
		coef_s1 <= coef;
		q2_s1 <= coef.flip ? -q2 : q2;
		rmag_s1 <= r2[R2_W-1] ? jrpw_pkg::DET_COUNT_W'(-r2) : jrpw_pkg::DET_COUNT_W'(r2);
		rneg_s1 <= r2[R2_W-1] ^ (coef.flip & coef.xdrv);
	end

	// Stage 2: offset times spacing, slope times step
	logic signed [KQ_W-1:0] kq_c;
	assign kq_c = KQ_W'($signed({1'b0, coef_s1.k})) * KQ_W'(q2_s1);

	always_ff @(posedge clk) begin
		a_s2 <= A_W'(rmag_s1) * A_W'(cfg.spacing);
		kq_s2 <= kq_c;
		row_s2 <= row_s1;
		step_s2 <= step_s1;
		m_s2 <= coef_s1.m;
		xdrv_s2 <= coef_s1.xdrv;
		ok_s2 <= coef_s1.angle_ok;
		rneg_s2 <= rneg_s1;
	end

	// Stage 3: split product of offset and 1/|cos| or 1/|sin|, center minus slope term
	logic signed [jrpw_pkg::IMAGE_SIZE_W:0] nxm1;
	logic signed [BASE_W-1:0] base;
	logic signed [RW-1:0] bk_c;

	always_comb begin
		nxm1 = $signed({1'b0, cfg.nx}) - (jrpw_pkg::IMAGE_SIZE_W+1)'(1);
		base = $signed({nxm1, 31'd0});
		bk_c = RW'(base) - (RW'(kq_s2) <<< 1);
	end

	always_ff @(posedge clk) begin
		ph_s3 <= PH_W'(a_s2[A_W-1:A_SPLIT]) * PH_W'(m_s2);
		pl_s3 <= PL_W'(a_s2[A_SPLIT-1:0]) * PL_W'(m_s2);
		bk_s3 <= bk_c;
		row_s3 <= row_s2;
		step_s3 <= step_s2;
		m_s3 <= m_s2;
		xdrv_s3 <= xdrv_s2;
		ok_s3 <= ok_s2;
		rneg_s3 <= rneg_s2;
	end

	// Stage 4: join partial products, truncate, apply offset term
	logic [RM_FULL_W-1:0] rm_full;
	logic signed [RW-1:0] rm;
	logic signed [RW-1:0] ray_c;

	always_comb begin
		rm_full = {ph_s3, A_SPLIT'(0)} + RM_FULL_W'(pl_s3);
		rm = $signed(RW'(rm_full[RM_FULL_W-1:RM_SHIFT]));
		ray_c = rneg_s3 ? bk_s3 + rm : bk_s3 - rm;
	end

	always_ff @(posedge clk) begin
		ray_s4 <= ray_c;
		row_s4 <= row_s3;
		step_s4 <= step_s3;
		m_s4 <= m_s3;
		xdrv_s4 <= xdrv_s3;
		ok_s4 <= ok_s3;
	end

	// Hand the ray over as floor and fraction
	always_comb begin
		ray.valid = valid_s4;
		ray.row = row_s4;
		ray.step = step_s4;
		ray.m = m_s4;
		ray.xdrv = xdrv_s4;
		ray.angle_ok = ok_s4;
		ray.fl = ray_s4[RW-1:jrpw_pkg::FRAC_W];
		ray.frac = ray_s4[jrpw_pkg::FRAC_W-1:0];
	end

endmodule

### hdl/jrpw_weight_stage.sv
// Weight pipe, stages 5 and 6: interpolation weights, neighbor pixel indexes
// and image bounds, ending in the result register. Depends on jrpw_pkg.
`timescale 1ns / 1ps

module jrpw_weight_stage #(
	parameter int FRACTION_BITS = jrpw_pkg::FRACTION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input jrpw_pkg::ray_t ray,
	input jrpw_pkg::cfg_t cfg,
	output logic done,
	output jrpw_pkg::result_t result
);

	localparam int NXW = jrpw_pkg::IMAGE_SIZE_W;
	localparam int FLW = jrpw_pkg::FL_W;
	localparam int CW = jrpw_pkg::COEF_W;
	localparam int PW = jrpw_pkg::FRAC_W + CW;
	localparam int WSHIFT = 62 - FRACTION_BITS;
	localparam int COLW = 2 * NXW;

	// Stage 5: bounds, column base product, fraction times scale
	logic signed [FLW:0] lat1;
	logic step_in, in0, in1;
	logic [NXW:0] sel, add;
	logic [NXW-1:0] incr;

	// Keep the floor signed so a ray just below the image still puts its
	// upper neighbor on row or column zero
	always_comb begin
		lat1 = $signed({ray.fl[FLW-1], ray.fl}) + (FLW+1)'(1);
		step_in = {1'b0, ray.step} < cfg.nx;
		in0 = ray.angle_ok && step_in && !ray.fl[FLW-1]
			&& ($signed(ray.fl) < $signed(FLW'(cfg.nx)));
		in1 = ray.angle_ok && step_in && !lat1[FLW]
			&& (lat1 < $signed((FLW+1)'(cfg.nx)));
		sel = ray.xdrv ? ray.fl[NXW:0] : (NXW+1)'(ray.step);
		add = ray.xdrv ? (NXW+1)'(ray.step) : ray.fl[NXW:0];
		incr = ray.xdrv ? cfg.nx : NXW'(1);
	end

	logic valid_s5, valid_s6;
	logic [jrpw_pkg::INDEX_W-1:0] row_s5;
	logic [PW-1:0] prod_s5;
	logic [CW-1:0] m_s5;
	logic [COLW-1:0] base_s5;
	logic [NXW:0] add_s5;
	logic [NXW-1:0] incr_s5;
	logic in0_s5, in1_s5;
	jrpw_pkg::result_t result_s6;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s5 <= ray.valid;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		row_s5 <= ray.row;
		prod_s5 <= PW'(ray.frac) * PW'(ray.m);
		m_s5 <= ray.m;
		base_s5 <= COLW'($signed(sel)) * COLW'(cfg.nx);
		add_s5 <= add;
		incr_s5 <= incr;
		in0_s5 <= in0;
		in1_s5 <= in1;
	end

	// Stage 6: weights from the shared product, columns by offset
	logic [COLW-1:0] col0, col1;
	logic [PW-1:0] w0_full, w0_shift, w1_shift;

	always_comb begin
		col0 = base_s5 + COLW'($signed(add_s5));
		col1 = col0 + COLW'(incr_s5);
		w0_full = {m_s5, jrpw_pkg::FRAC_W'(0)} - prod_s5;
		w0_shift = w0_full >> WSHIFT;
		w1_shift = prod_s5 >> WSHIFT;
	end

	always_ff @(posedge clk) begin
		result_s6.row_index <= row_s5;
		result_s6.first_valid <= in0_s5;
		result_s6.first_column <= in0_s5 ? jrpw_pkg::INDEX_W'(col0) : '0;
		result_s6.first_weight <= in0_s5 ? w0_shift[jrpw_pkg::WEIGHT_W-1:0] : '0;
		result_s6.second_valid <= in1_s5;
		result_s6.second_column <= in1_s5 ? jrpw_pkg::INDEX_W'(col1) : '0;
		result_s6.second_weight <= in1_s5 ? w1_shift[jrpw_pkg::WEIGHT_W-1:0] : '0;
	end

	assign done = valid_s6;
	assign result = result_s6;

	// Neighbors along the crossing axis never share a pixel
	a_distinct_cols: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 && result_s6.first_valid && result_s6.second_valid
		|-> result_s6.first_column != result_s6.second_column)
		else $error("neighbor pixels share one column");

endmodule

### hdl/joseph_ray_pixel_weights.sv
// Top level of the parallel-beam ray pixel weight pipeline: configuration
// registers, geometry pipe and weight stage. Depends on jrpw_pkg and its modules.
`timescale 1ns / 1ps

// One item enters on every clock where start is high and busy is low; its
// result appears on result with done high for exactly one cycle, and items
// leave in the order they came. The six register stages (table read, two
// multiply stages for the detector offset, ray sum, weight product, output
// register) lie between request and result; throughput is one item per
// clock with no gaps. Nothing can hold results back, so the receiver must
// take each one the cycle it shows. busy is set during reset and cleared on
// every clock after it. The per-angle coefficient table is built when the
// design is elaborated, so there is no fill time after reset. Write the
// configuration registers only while no item is in flight.
module joseph_ray_pixel_weights #(
	parameter int ANGLE_COUNT = jrpw_pkg::ANGLE_COUNT_DEF,
	parameter int MAX_IMAGE_SIZE = jrpw_pkg::MAX_IMAGE_SIZE_DEF,
	parameter int MAX_DETECTORS = jrpw_pkg::MAX_DETECTORS_DEF,
	parameter int FRACTION_BITS = jrpw_pkg::FRACTION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input jrpw_pkg::request_t request,
	output logic done,
	output jrpw_pkg::result_t result,
	input logic cfg_write,
	input logic [jrpw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [jrpw_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic busy_q;
	logic accept;
	jrpw_pkg::cfg_t cfg;
	jrpw_pkg::ray_t ray;

	// Hold busy high through reset, clearing it on the next clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign accept = start && !busy_q;

	jrpw_cfg_regs #(
		.MAX_IMAGE_SIZE(MAX_IMAGE_SIZE),
		.MAX_DETECTORS(MAX_DETECTORS)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	jrpw_ray_pipe #(
		.ANGLE_COUNT(ANGLE_COUNT)
	) u_ray (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.request(request),
		.cfg(cfg),
		.ray(ray)
	);

	jrpw_weight_stage #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_weight (
		.clk(clk),
		.arst_n(arst_n),
		.ray(ray),
		.cfg(cfg),
		.done(done),
		.result(result)
	);

	// Every accepted item comes out with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("accepted item produced no result");

	// No result without an accepted item before it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result without an accepted item");

	// Angles past the table give no pixels
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && (32'($past(request.angle_index, 6)) >= ANGLE_COUNT)
		|-> !result.first_valid && !result.second_valid)
		else $error("pixel flagged valid for an angle beyond the count");

endmodule
